// ===== rtl/bond_loop_filter_table_macros.svh =====
// ----------------------------------------------------------------------------
// bond loop filter table assertion macros
// shared property forms for the block's checks
// ----------------------------------------------------------------------------
`ifndef BOND_LOOP_FILTER_TABLE_MACROS_SVH
`define BOND_LOOP_FILTER_TABLE_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define BLFT_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bond loop filter table check failed");

// next-cycle implication, disabled while reset is low
`define BLFT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bond loop filter table check failed");

`endif

// ===== rtl/blft_pkg.sv =====
// ----------------------------------------------------------------------------
// blft_pkg
// types and constants shared by the loop filter table modules
// ----------------------------------------------------------------------------
package blft_pkg;

    localparam logic [1:0] OP_EGRESS = 2'd0;
    localparam logic [1:0] OP_INGRESS = 2'd1;
    localparam logic [1:0] OP_ACTIVE = 2'd2;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    localparam logic [2:0] CLS_UCAST = 3'd0;
    localparam logic [2:0] CLS_MCAST = 3'd1;
    localparam logic [2:0] CLS_IGMP = 3'd2;
    localparam logic [2:0] CLS_GARP = 3'd3;
    localparam logic [2:0] CLS_PARSE = 3'd4;
    localparam logic [2:0] CLS_UNDEF = 3'd7;

    localparam logic [1:0] RSN_NONE = 2'd0;
    localparam logic [1:0] RSN_LOOP = 2'd1;
    localparam logic [1:0] RSN_MCAST = 2'd2;
    localparam logic [1:0] RSN_EXPIRED = 2'd3;

    localparam logic [1:0] REG_STATE_LT = 2'd0;
    localparam logic [1:0] REG_LOCK_LT = 2'd1;
    localparam logic [1:0] REG_BOND_IF = 2'd2;
    localparam logic [1:0] REG_NS_COOKIE = 2'd3;

    typedef struct packed {
        logic [1:0]  op;
        logic [47:0] src_mac;
        logic [15:0] vlan_tag;
        logic [15:0] port_index;
        logic [2:0]  pkt_class;
        logic [63:0] time_now;
        logic [15:0] next_active;
        logic [63:0] event_cookie;
    } t_item;

    typedef struct packed {
        logic [39:0] learn_ttl;
        logic [39:0] lock_ttl;
        logic [15:0] bond_interface;
        logic [63:0] namespace_cookie;
    } t_cfg;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LOAD,
        ST_SCAN,
        ST_DECIDE,
        ST_BRANCH,
        ST_TOUCH,
        ST_READ,
        ST_UPDATE,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic load;
        logic quick;
        logic scan_start;
        logic decide;
        logic touch_start;
        logic miss_res;
        logic ent_read;
        logic ent_write;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic in_valid;
        logic needs_table;
        logic pass_done;
        logic tgt_ok;
        logic out_busy;
    } t_sts;

endpackage

// ===== rtl/blft_ctrl.sv =====
// ----------------------------------------------------------------------------
// blft_ctrl
// sequencer for one item: scan, decide, lru pass, entry update, result
// ----------------------------------------------------------------------------
module blft_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  blft_pkg::t_sts    i_sts,
    output blft_pkg::t_cmd    o_cmd,
    output logic              o_ready
);

    blft_pkg::t_state r_state;
    blft_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= blft_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            blft_pkg::ST_IDLE: begin
                if (i_sts.in_valid) n_state = blft_pkg::ST_LOAD;
            end
            blft_pkg::ST_LOAD: begin
                n_state = i_sts.needs_table ? blft_pkg::ST_SCAN : blft_pkg::ST_DONE;
            end
            blft_pkg::ST_SCAN: begin
                if (i_sts.pass_done) n_state = blft_pkg::ST_DECIDE;
            end
            blft_pkg::ST_DECIDE: n_state = blft_pkg::ST_BRANCH;
            blft_pkg::ST_BRANCH: begin
                n_state = i_sts.tgt_ok ? blft_pkg::ST_TOUCH : blft_pkg::ST_DONE;
            end
            blft_pkg::ST_TOUCH: begin
                if (i_sts.pass_done) n_state = blft_pkg::ST_READ;
            end
            blft_pkg::ST_READ: n_state = blft_pkg::ST_UPDATE;
            blft_pkg::ST_UPDATE: n_state = blft_pkg::ST_DONE;
            blft_pkg::ST_DONE: begin
                if (!i_sts.out_busy) n_state = blft_pkg::ST_IDLE;
            end
            default: n_state = blft_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        o_ready = 1'b0;
        case (r_state)
            blft_pkg::ST_IDLE: begin
                o_ready = 1'b1;
                o_cmd.load = i_sts.in_valid;
            end
            blft_pkg::ST_LOAD: begin
                o_cmd.scan_start = i_sts.needs_table;
                o_cmd.quick = !i_sts.needs_table;
            end
            blft_pkg::ST_DECIDE: o_cmd.decide = 1'b1;
            blft_pkg::ST_BRANCH: begin
                o_cmd.touch_start = i_sts.tgt_ok;
                o_cmd.miss_res = !i_sts.tgt_ok;
            end
            blft_pkg::ST_READ: o_cmd.ent_read = 1'b1;
            blft_pkg::ST_UPDATE: o_cmd.ent_write = 1'b1;
            blft_pkg::ST_DONE: o_cmd.emit = !i_sts.out_busy;
            default: o_cmd = '0;
        endcase
    end

endmodule

// ===== rtl/blft_dp.sv =====
// ----------------------------------------------------------------------------
// blft_dp
// entry memories, scan and lru passes, entry update and result register
// ----------------------------------------------------------------------------
module blft_dp #(
    parameter int ENTRIES = 64
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  blft_pkg::t_cmd    i_cmd,
    input  blft_pkg::t_item   i_item,
    input  blft_pkg::t_cfg    i_cfg,
    input  logic              i_in_valid,
    input  logic              i_out_ready,
    output blft_pkg::t_sts    o_sts,
    output logic              o_out_valid,
    output logic              o_drop,
    output logic [1:0]        o_drop_reason
);

    localparam int IW = $clog2(ENTRIES);
    localparam logic [IW:0] FULL = (IW + 1)'(ENTRIES);
    localparam logic [IW-1:0] AGE_MAX = IW'(ENTRIES - 1);

    logic [63:0] key_mem  [ENTRIES];
    logic [IW-1:0] age_mem [ENTRIES];
    logic [15:0] port_mem [ENTRIES];
    logic [63:0] exp_mem  [ENTRIES];
    logic [63:0] lock_mem [ENTRIES];
    logic [63:0] drop_mem [ENTRIES];

    blft_pkg::t_item r_item;
    logic [IW:0]     r_fill;
    logic [IW-1:0]   r_cnt;
    logic            r_run;
    logic            r_touch_mode;
    logic            r_rd_vld;
    logic [IW-1:0]   r_rd_idx;
    logic [63:0]     r_key_q;
    logic [IW-1:0]   r_age_q;
    logic            r_hit;
    logic [IW-1:0]   r_hit_idx;
    logic [IW-1:0]   r_hit_age;
    logic [IW-1:0]   r_old_idx;
    logic [IW-1:0]   r_old_age;
    logic            r_do_touch;
    logic            r_new;
    logic [IW-1:0]   r_tgt_idx;
    logic [IW-1:0]   r_tgt_age;
    logic [15:0]     r_port_q;
    logic [63:0]     r_exp_q;
    logic [63:0]     r_lock_q;
    logic [63:0]     r_drops_q;
    logic [15:0]     r_active;
    logic            r_res_drop;
    logic [1:0]      r_res_reason;
    logic            r_out_valid;
    logic            r_out_drop;
    logic [1:0]      r_out_reason;

    logic [63:0]     w_key;
    logic            w_mc_off;
    logic            w_garp;
    logic            w_last;
    logic [IW-1:0]   w_age_new;
    logic [IW-1:0]   w_ins_slot;

    assign w_key = {r_item.src_mac, r_item.vlan_tag};
    assign w_garp = (r_item.pkt_class == blft_pkg::CLS_GARP);
    assign w_mc_off = ((r_item.pkt_class == blft_pkg::CLS_MCAST) ||
                       (r_item.pkt_class == blft_pkg::CLS_IGMP)) &&
                      (r_item.port_index != r_active);
    assign w_last = (({1'b0, r_cnt} + (IW + 1)'(1)) == r_fill);
    assign w_ins_slot = (r_fill < FULL) ? r_fill[IW-1:0] : r_old_idx;
    assign w_age_new = (r_rd_idx == r_tgt_idx) ? '0 :
                       ((r_age_q < r_tgt_age) ? r_age_q + IW'(1) : r_age_q);

    assign o_sts.in_valid = i_in_valid;
    assign o_sts.needs_table = (r_item.op == blft_pkg::OP_EGRESS ||
                                r_item.op == blft_pkg::OP_INGRESS) &&
                               (r_item.pkt_class <= blft_pkg::CLS_GARP);
    assign o_sts.pass_done = !r_run && !r_rd_vld;
    assign o_sts.tgt_ok = r_do_touch;
    assign o_sts.out_busy = r_out_valid && !i_out_ready;

    // key and age memories: one read per pass step, registered
    always_ff @(posedge i_clk) begin
        r_key_q <= key_mem[r_cnt];
        r_age_q <= age_mem[r_cnt];
        if (i_cmd.decide && !r_hit && r_item.op == blft_pkg::OP_EGRESS) begin
            key_mem[w_ins_slot] <= w_key;
        end
        if (r_rd_vld && r_touch_mode) begin
            age_mem[r_rd_idx] <= w_age_new;
        end
    end

    // entry payload memories
    always_ff @(posedge i_clk) begin
        if (i_cmd.ent_read) begin
            r_port_q <= port_mem[r_tgt_idx];
            r_exp_q <= exp_mem[r_tgt_idx];
            r_lock_q <= lock_mem[r_tgt_idx];
            r_drops_q <= drop_mem[r_tgt_idx];
        end
        if (i_cmd.ent_write) begin
            if (r_item.op == blft_pkg::OP_EGRESS) begin
                port_mem[r_tgt_idx] <= r_item.port_index;
                exp_mem[r_tgt_idx] <= r_item.time_now + {24'd0, i_cfg.learn_ttl};
                if (w_garp) begin
                    lock_mem[r_tgt_idx] <= r_item.time_now + {24'd0, i_cfg.lock_ttl};
                end else if (r_new) begin
                    lock_mem[r_tgt_idx] <= '0;
                end
                if (r_new) drop_mem[r_tgt_idx] <= '0;
            end else if (r_exp_q > r_item.time_now && r_port_q != r_item.port_index) begin
                // live entry from another interface
                if (w_garp && r_lock_q < r_item.time_now) begin
                    exp_mem[r_tgt_idx] <= '0;
                end else begin
                    drop_mem[r_tgt_idx] <= r_drops_q + 64'd1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) r_item <= i_item;
        if (i_cmd.scan_start) begin
            r_hit <= 1'b0;
            r_old_idx <= '0;
            r_old_age <= '0;
        end
        if (r_rd_vld && !r_touch_mode) begin
            if (r_key_q == w_key) begin
                r_hit <= 1'b1;
                r_hit_idx <= r_rd_idx;
                r_hit_age <= r_age_q;
            end
            if (r_rd_idx == '0 || r_age_q > r_old_age) begin
                r_old_idx <= r_rd_idx;
                r_old_age <= r_age_q;
            end
        end
        if (i_cmd.decide) begin
            r_new <= !r_hit;
            if (r_hit) begin
                r_tgt_idx <= r_hit_idx;
                r_tgt_age <= r_hit_age;
            end else begin
                r_tgt_idx <= w_ins_slot;
                r_tgt_age <= (r_fill < FULL) ? AGE_MAX : r_old_age;
            end
        end
        if (i_cmd.quick || i_cmd.miss_res) begin
            r_res_drop <= i_cmd.miss_res && r_item.op == blft_pkg::OP_INGRESS && w_mc_off;
            r_res_reason <= (i_cmd.miss_res && r_item.op == blft_pkg::OP_INGRESS && w_mc_off)
                            ? blft_pkg::RSN_MCAST : blft_pkg::RSN_NONE;
        end
        if (i_cmd.ent_write) begin
            if (r_item.op == blft_pkg::OP_EGRESS) begin
                r_res_drop <= 1'b0;
                r_res_reason <= blft_pkg::RSN_NONE;
            end else if (r_exp_q > r_item.time_now && r_port_q != r_item.port_index) begin
                if (w_garp && r_lock_q < r_item.time_now) begin
                    r_res_drop <= 1'b0;
                    r_res_reason <= blft_pkg::RSN_EXPIRED;
                end else begin
                    r_res_drop <= 1'b1;
                    r_res_reason <= blft_pkg::RSN_LOOP;
                end
            end else begin
                r_res_drop <= w_mc_off;
                r_res_reason <= w_mc_off ? blft_pkg::RSN_MCAST : blft_pkg::RSN_NONE;
            end
        end
        if (i_cmd.emit) begin
            r_out_drop <= r_res_drop;
            r_out_reason <= r_res_reason;
        end
    end

    // control state: fill count, pass counter, active port, output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
            r_run <= 1'b0;
            r_rd_vld <= 1'b0;
            r_touch_mode <= 1'b0;
            r_cnt <= '0;
            r_do_touch <= 1'b0;
            r_active <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_rd_vld <= r_run;
            r_rd_idx <= r_cnt;
            if (r_run) begin
                r_cnt <= r_cnt + IW'(1);
                if (w_last) r_run <= 1'b0;
            end
            if (i_cmd.scan_start || i_cmd.touch_start) begin
                r_cnt <= '0;
                r_run <= (r_fill != '0);
                r_touch_mode <= i_cmd.touch_start;
            end
            if (i_cmd.decide) begin
                r_do_touch <= r_hit || r_item.op == blft_pkg::OP_EGRESS;
                if (!r_hit && r_item.op == blft_pkg::OP_EGRESS && r_fill < FULL) begin
                    r_fill <= r_fill + (IW + 1)'(1);
                end
            end
            if (i_cmd.quick && r_item.op == blft_pkg::OP_ACTIVE &&
                r_item.event_cookie == i_cfg.namespace_cookie &&
                r_item.port_index == i_cfg.bond_interface &&
                r_item.next_active != 16'd0) begin
                r_active <= r_item.next_active;
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_drop = r_out_drop;
    assign o_drop_reason = r_out_reason;

endmodule

// ===== rtl/bond_loop_filter_table.sv =====
// ----------------------------------------------------------------------------
// bond_loop_filter_table
// loop filter table for a bonded link, lru keyed on source mac and vlan
// ----------------------------------------------------------------------------
// usage
//   s_axis carries one packet or event per transfer, m_axis returns one
//   verdict (drop, drop_reason) per input transfer, in order; the apb port
//   writes and reads the four lifetime/bond/cookie registers (64-bit data,
//   register i at byte address 8*i); the user must write them only while
//   idle, which the block does not enforce
// item flow
//   events and items that need no table: the verdict is set in the load
//   state and goes out from the done state; hit or egress miss table items:
//   a single-port scan pass for the key lookup, an age pass for the lru
//   update, then one read-modify-write of the chosen entry; an ingress miss
//   has the scan pass only; one item is in work at a time, and the next is
//   taken once the verdict is loaded into the output register
// reset
//   the table comes up empty through a fill count, active port is zero,
//   registers take their reset values; no clearing pass is needed
// stall
//   a verdict waits in the output register while m_axis_tready is low; the
//   next item is accepted and worked, then holds until the register frees
// ----------------------------------------------------------------------------
`include "bond_loop_filter_table_macros.svh"

module bond_loop_filter_table #(
    parameter int ENTRIES = 64
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    // input stream
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    // src_mac[47:0], vlan_tag[63:48], port_index[79:64], time_now[143:80],
    // next_active[159:144], event_cookie[223:160]
    input  logic [223:0]  s_axis_tdata,
    // op[1:0], pkt_class[4:2]
    input  logic [4:0]    s_axis_tuser,
    // verdict stream
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    // drop[0], drop_reason[2:1], zero fill [7:3]
    output logic [7:0]    m_axis_tdata,
    // configuration port
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [4:0]    paddr,
    input  logic [63:0]   pwdata,
    output logic [63:0]   prdata,
    output logic          pready
);

    blft_pkg::t_cfg  r_cfg;
    blft_pkg::t_item w_item;
    blft_pkg::t_cmd  w_cmd;
    blft_pkg::t_sts  w_sts;
    logic            w_drop;
    logic [1:0]      w_reason;
    logic [1:0]      w_reg_idx;

    assign pready = 1'b1;
    assign w_reg_idx = paddr[4:3];

    // register file, written on the access phase of an apb write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.learn_ttl <= 40'd60000000000;
            r_cfg.lock_ttl <= 40'd5000000000;
            r_cfg.bond_interface <= '0;
            r_cfg.namespace_cookie <= '0;
        end else if (psel && penable && pwrite) begin
            case (w_reg_idx)
                blft_pkg::REG_STATE_LT: r_cfg.learn_ttl <= pwdata[39:0];
                blft_pkg::REG_LOCK_LT: r_cfg.lock_ttl <= pwdata[39:0];
                blft_pkg::REG_BOND_IF: r_cfg.bond_interface <= pwdata[15:0];
                blft_pkg::REG_NS_COOKIE: r_cfg.namespace_cookie <= pwdata;
                default: r_cfg.namespace_cookie <= r_cfg.namespace_cookie;
            endcase
        end
    end

    always_comb begin
        case (w_reg_idx)
            blft_pkg::REG_STATE_LT: prdata = {24'd0, r_cfg.learn_ttl};
            blft_pkg::REG_LOCK_LT: prdata = {24'd0, r_cfg.lock_ttl};
            blft_pkg::REG_BOND_IF: prdata = {48'd0, r_cfg.bond_interface};
            blft_pkg::REG_NS_COOKIE: prdata = r_cfg.namespace_cookie;
            default: prdata = '0;
        endcase
    end

    // unpack the input transfer
    assign w_item.op = s_axis_tuser[1:0];
    assign w_item.pkt_class = s_axis_tuser[4:2];
    assign w_item.src_mac = s_axis_tdata[47:0];
    assign w_item.vlan_tag = s_axis_tdata[63:48];
    assign w_item.port_index = s_axis_tdata[79:64];
    assign w_item.time_now = s_axis_tdata[143:80];
    assign w_item.next_active = s_axis_tdata[159:144];
    assign w_item.event_cookie = s_axis_tdata[223:160];

    blft_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd),
        .o_ready (s_axis_tready)
    );

    blft_dp #(
        .ENTRIES (ENTRIES)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .i_item        (w_item),
        .i_cfg         (r_cfg),
        .i_in_valid    (s_axis_tvalid),
        .i_out_ready   (m_axis_tready),
        .o_sts         (w_sts),
        .o_out_valid   (m_axis_tvalid),
        .o_drop        (w_drop),
        .o_drop_reason (w_reason)
    );

    assign m_axis_tdata = {5'd0, w_reason, w_drop};

    // a verdict drops exactly when the reason is a loop or multicast drop
    `BLFT_ASSERT_NOW(a_drop_reason, i_clk, i_rst_n, m_axis_tvalid,
        m_axis_tdata[0] == (m_axis_tdata[2:1] == blft_pkg::RSN_LOOP ||
        m_axis_tdata[2:1] == blft_pkg::RSN_MCAST))
    // one item at a time: no accept in the cycle after an accept
    `BLFT_ASSERT_NEXT(a_one_item, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready,
        !s_axis_tready)
    // a fresh verdict never appears right after an accept
    `BLFT_ASSERT_NEXT(a_min_latency, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready,
        !$rose(m_axis_tvalid))

endmodule

// ===== tb/bond_loop_filter_table_test.sv =====
// ----------------------------------------------------------------------------
// bond_loop_filter_table_test
// self-checking bench for the bonded-link loop filter table: a directed table
// of packets and events, then random traffic in four phases under different
// register settings and handshake pressure; each verdict is compared with its
// typed row's verdict, else with a behavioral lru table copy kept in the bench
// ----------------------------------------------------------------------------
module bond_loop_filter_table_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ENTRIES = 64;
    localparam logic [39:0] LT_MAX = 40'hFF_FFFF_FFFF;

    // one directed row: the item and, where obvious, the verdict it must get
    typedef struct {
        blft_pkg::t_item it;
        bit              typed;
        bit              drop;
        logic [1:0]      reason;
    } t_row;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    // src_mac, vlan_tag, port_index, time_now, next_active, event_cookie
    logic [223:0] s_axis_tdata = '0;
    // op[1:0], pkt_class[4:2]
    logic [4:0]   s_axis_tuser = '0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    // drop[0], drop_reason[2:1]
    logic [7:0]   m_axis_tdata;
    logic         psel = 1'b0;
    logic         penable = 1'b0;
    logic         pwrite = 1'b0;
    logic [4:0]   paddr = '0;
    logic [63:0]  pwdata = '0;
    logic [63:0]  prdata;
    logic         pready;

    bond_loop_filter_table #(.ENTRIES(ENTRIES)) dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always #1 i_clk = ~i_clk;

    // behavioral copy of the filter table and its registers
    logic [63:0]    tbl_key    [ENTRIES];
    bit             tbl_valid  [ENTRIES];
    logic [15:0]    tbl_port   [ENTRIES];
    logic [63:0]    tbl_expiry [ENTRIES];
    logic [63:0]    tbl_lock   [ENTRIES];
    logic [63:0]    tbl_drops  [ENTRIES];
    int             tbl_age    [ENTRIES];
    logic [15:0]    active_if;
    blft_pkg::t_cfg regs;

    // verdicts still owed by the block, oldest first: {reason, drop}
    logic [2:0]  verdicts_due[$];

    int errors = 0;
    int items_sent = 0;
    int verdicts_seen = 0;
    int drops_seen = 0;
    int evict_fills = 0;
    int gap_pct = 0;
    int stall_pct = 0;

    // typed verdict for the item currently on the bus, if any
    bit          cur_typed = 0;
    logic [2:0]  cur_verdict = '0;

    // key pools keep most traffic hitting the same few entries
    logic [47:0] mac_pool[8];
    logic [63:0] t_base = 64'd0;

    task automatic report_mismatch(input string what, input logic [1:0] got,
                                   input logic [1:0] want);
        $display("mismatch: %s got %0d expected %0d (verdict %0d)", what, got, want,
                 verdicts_seen);
        errors++;
    endtask

    function automatic void lru_touch(int idx);
        int a;
        a = tbl_age[idx];
        for (int j = 0; j < ENTRIES; j++)
            if (j != idx && tbl_valid[j] && tbl_age[j] < a)
                tbl_age[j]++;
        tbl_age[idx] = 0;
    endfunction

    function automatic int lru_insert(logic [63:0] key);
        int slot;
        slot = -1;
        for (int i = 0; i < ENTRIES; i++)
            if (!tbl_valid[i] && slot < 0)
                slot = i;
        if (slot < 0) begin
            slot = 0;
            for (int i = 1; i < ENTRIES; i++)
                if (tbl_age[i] > tbl_age[slot])
                    slot = i;
            evict_fills++;
        end else begin
            tbl_age[slot] = ENTRIES - 1;
        end
        tbl_valid[slot] = 1'b1;
        tbl_key[slot] = key;
        tbl_port[slot] = '0;
        tbl_expiry[slot] = '0;
        tbl_lock[slot] = '0;
        tbl_drops[slot] = '0;
        lru_touch(slot);
        return slot;
    endfunction

    function automatic int lookup(logic [63:0] key);
        for (int i = 0; i < ENTRIES; i++)
            if (tbl_valid[i] && tbl_key[i] == key)
                return i;
        return -1;
    endfunction

    // applies one item to the table copy and returns {reason, drop}
    function automatic logic [2:0] filter_verdict(blft_pkg::t_item it);
        logic [63:0] key;
        int idx;
        bit drop;
        bit handled;
        logic [1:0] reason;
        key = {it.src_mac, it.vlan_tag};
        drop = 0;
        reason = blft_pkg::RSN_NONE;
        handled = 0;
        if (it.op == blft_pkg::OP_EGRESS && it.pkt_class <= blft_pkg::CLS_GARP) begin
            idx = lookup(key);
            if (idx >= 0)
                lru_touch(idx);
            else
                idx = lru_insert(key);
            tbl_expiry[idx] = it.time_now + 64'(regs.learn_ttl);
            if (it.pkt_class == blft_pkg::CLS_GARP)
                tbl_lock[idx] = it.time_now + 64'(regs.lock_ttl);
            tbl_port[idx] = it.port_index;
        end else if (it.op == blft_pkg::OP_INGRESS && it.pkt_class <= blft_pkg::CLS_GARP) begin
            idx = lookup(key);
            if (idx >= 0) begin
                lru_touch(idx);
                // live entry learned on another interface
                if (tbl_expiry[idx] > it.time_now && tbl_port[idx] != it.port_index) begin
                    handled = 1;
                    if (it.pkt_class == blft_pkg::CLS_GARP && tbl_lock[idx] < it.time_now) begin
                        tbl_expiry[idx] = '0;
                        reason = blft_pkg::RSN_EXPIRED;
                    end else begin
                        tbl_drops[idx]++;
                        drop = 1;
                        reason = blft_pkg::RSN_LOOP;
                    end
                end
            end
            if (!handled && (it.pkt_class == blft_pkg::CLS_MCAST ||
                             it.pkt_class == blft_pkg::CLS_IGMP)
                && it.port_index != active_if) begin
                drop = 1;
                reason = blft_pkg::RSN_MCAST;
            end
        end else if (it.op == blft_pkg::OP_ACTIVE) begin
            if (it.event_cookie == regs.namespace_cookie
                && it.port_index == regs.bond_interface && it.next_active != 0)
                active_if = it.next_active;
        end
        return {reason, drop};
    endfunction

    function automatic blft_pkg::t_item decode_bus();
        blft_pkg::t_item it;
        it.op = s_axis_tuser[1:0];
        it.pkt_class = s_axis_tuser[4:2];
        it.src_mac = s_axis_tdata[47:0];
        it.vlan_tag = s_axis_tdata[63:48];
        it.port_index = s_axis_tdata[79:64];
        it.time_now = s_axis_tdata[143:80];
        it.next_active = s_axis_tdata[159:144];
        it.event_cookie = s_axis_tdata[223:160];
        return it;
    endfunction

    // transfers on both streams, seen at the rising edge
    always @(posedge i_clk) begin
        logic [2:0] want;
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready) begin
                want = filter_verdict(decode_bus());
                verdicts_due.push_back(cur_typed ? cur_verdict : want);
                items_sent++;
            end
            if (m_axis_tvalid && m_axis_tready) begin
                verdicts_seen++;
                drops_seen += m_axis_tdata[0];
                if (verdicts_due.size() == 0) begin
                    $display("unexpected verdict transfer, nothing outstanding");
                    errors++;
                end else begin
                    want = verdicts_due.pop_front();
                    if (m_axis_tdata[0] !== want[0])
                        report_mismatch("drop", 2'(m_axis_tdata[0]), 2'(want[0]));
                    if (m_axis_tdata[2:1] !== want[2:1])
                        report_mismatch("drop_reason", m_axis_tdata[2:1], want[2:1]);
                end
            end
        end
    end

    // receiver back-pressure
    always @(negedge i_clk)
        m_axis_tready <= (stall_pct == 0) ? 1'b1 : ($urandom_range(99) >= stall_pct);

    // one input transfer; starts and ends at a falling edge
    task automatic send(input blft_pkg::t_item it, input bit typed,
                        input logic [2:0] verdict);
        if (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= {it.pkt_class, it.op};
        s_axis_tdata <= {it.event_cookie, it.next_active, it.time_now, it.port_index,
                         it.vlan_tag, it.src_mac};
        cur_typed <= typed;
        cur_verdict <= verdict;
        do @(posedge i_clk); while (!s_axis_tready);
        @(negedge i_clk);
    endtask

    // register write, setup then access; only while the block is idle
    task automatic write_reg(input logic [1:0] idx, input logic [63:0] value);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= 5'(idx) << 3;
        pwdata <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            blft_pkg::REG_STATE_LT:  regs.learn_ttl = value[39:0];
            blft_pkg::REG_LOCK_LT:   regs.lock_ttl = value[39:0];
            blft_pkg::REG_BOND_IF:   regs.bond_interface = value[15:0];
            blft_pkg::REG_NS_COOKIE: regs.namespace_cookie = value;
            default: ;
        endcase
    endtask

    // stop driving and let every owed verdict drain
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        cur_typed <= 1'b0;
        @(negedge i_clk);
        while (verdicts_due.size() != 0)
            @(negedge i_clk);
        repeat (8) @(negedge i_clk);
    endtask

    function automatic blft_pkg::t_item mk(logic [1:0] op, logic [47:0] mac,
                                           logic [15:0] vlan, logic [15:0] port,
                                           logic [2:0] cls, logic [63:0] now,
                                           logic [15:0] nact, logic [63:0] cookie);
        blft_pkg::t_item it;
        it.op = op;
        it.src_mac = mac;
        it.vlan_tag = vlan;
        it.port_index = port;
        it.pkt_class = cls;
        it.time_now = now;
        it.next_active = nact;
        it.event_cookie = cookie;
        return it;
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // random traffic: mostly a small set of keys, ports and nearby times,
    // so entries get learned, meet loops, expire and get locked
    function automatic blft_pkg::t_item random_item(bit fresh_key);
        blft_pkg::t_item it;
        int pick;
        it.src_mac = fresh_key ? 48'(rand64()) : mac_pool[$urandom_range(7)];
        it.vlan_tag = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(1));
        pick = $urandom_range(9);
        it.port_index = (pick < 8) ? 16'($urandom_range(1, 3)) : 16'($urandom);
        pick = $urandom_range(99);
        if (fresh_key)
            it.op = blft_pkg::OP_EGRESS;
        else if (pick < 40)
            it.op = blft_pkg::OP_EGRESS;
        else if (pick < 85)
            it.op = blft_pkg::OP_INGRESS;
        else if (pick < 97)
            it.op = blft_pkg::OP_ACTIVE;
        else
            it.op = blft_pkg::OP_UNUSED;
        it.pkt_class = ($urandom_range(9) == 0) ? 3'($urandom_range(4, 7))
                                                : 3'($urandom_range(0, 3));
        it.time_now = ($urandom_range(19) == 0) ? rand64()
                     : t_base + 64'($urandom_range(1000)) * 64'd100_000_000;
        it.next_active = ($urandom_range(5) == 0) ? 16'd0 : 16'($urandom_range(1, 3));
        it.event_cookie = ($urandom_range(3) == 0) ? rand64() : regs.namespace_cookie;
        if (it.op == blft_pkg::OP_ACTIVE && $urandom_range(3) != 0)
            it.port_index = regs.bond_interface;
        if ($urandom_range(49) == 0)
            it.next_active = 16'($urandom);
        return it;
    endfunction

    t_row dir_rows[$];

    initial begin
        #1_000_000;
        $display("timeout waiting for the block");
        $display("bond_loop_filter_table_test: done, errors");
        $finish;
    end

    initial begin
        logic [63:0] cookie;
        logic [15:0] bond;
        t_row row;

        for (int i = 0; i < ENTRIES; i++) begin
            tbl_valid[i] = 0;
            tbl_age[i] = 0;
        end
        active_if = '0;
        regs.learn_ttl = 40'd60_000_000_000;
        regs.lock_ttl = 40'd5_000_000_000;
        regs.bond_interface = '0;
        regs.namespace_cookie = '0;
        mac_pool[0] = '0;
        mac_pool[1] = '1;
        for (int i = 2; i < 8; i++)
            mac_pool[i] = 48'(rand64());

        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: after reset active port is zero, then learn, loop, lock, expire
        dir_rows = '{
            '{mk(blft_pkg::OP_INGRESS, 48'h1, 16'h1, 16'd7, blft_pkg::CLS_MCAST, 64'd10,
                 '0, '0), 1, 1, blft_pkg::RSN_MCAST},
            '{mk(blft_pkg::OP_INGRESS, 48'h1, 16'h1, 16'd0, blft_pkg::CLS_IGMP, 64'd10,
                 '0, '0), 1, 0, blft_pkg::RSN_NONE},
            '{mk(blft_pkg::OP_UNUSED, '1, '1, '1, blft_pkg::CLS_UNDEF, '1, '1, '1),
              1, 0, blft_pkg::RSN_NONE},
            '{mk(blft_pkg::OP_INGRESS, 48'h2, 16'h0, 16'd7, blft_pkg::CLS_PARSE, 64'd10,
                 '0, '0), 1, 0, blft_pkg::RSN_NONE},
            '{mk(blft_pkg::OP_INGRESS, 48'h2, 16'h0, 16'd7, blft_pkg::CLS_UNDEF, 64'd10,
                 '0, '0), 1, 0, blft_pkg::RSN_NONE},
            '{mk(blft_pkg::OP_EGRESS, '1, '1, 16'd1, blft_pkg::CLS_UCAST, 64'd100,
                 '0, '0), 1, 0, blft_pkg::RSN_NONE},
            '{mk(blft_pkg::OP_INGRESS, '1, '1, 16'd2, blft_pkg::CLS_UCAST, 64'd200,
                 '0, '0), 1, 1, blft_pkg::RSN_LOOP},
            '{mk(blft_pkg::OP_EGRESS, '1, '1, 16'd1, blft_pkg::CLS_GARP, 64'd300,
                 '0, '0), 1, 0, blft_pkg::RSN_NONE},
            // locked gratuitous arp still counts as a loop
            '{mk(blft_pkg::OP_INGRESS, '1, '1, 16'd2, blft_pkg::CLS_GARP, 64'd400,
                 '0, '0), 1, 1, blft_pkg::RSN_LOOP},
            // lock run out: the arp expires the entry and passes
            '{mk(blft_pkg::OP_INGRESS, '1, '1, 16'd2, blft_pkg::CLS_GARP,
                 64'd6_000_000_000, '0, '0), 1, 0, blft_pkg::RSN_EXPIRED},
            '{mk(blft_pkg::OP_INGRESS, '1, '1, 16'd2, blft_pkg::CLS_UCAST,
                 64'd6_000_000_001, '0, '0), 1, 0, blft_pkg::RSN_NONE},
            '{mk(blft_pkg::OP_ACTIVE, 48'h0, 16'h0, 16'd0, blft_pkg::CLS_UCAST, 64'd0,
                 16'd9, 64'd0), 1, 0, blft_pkg::RSN_NONE},
            '{mk(blft_pkg::OP_INGRESS, 48'h5, 16'h5, 16'd9, blft_pkg::CLS_MCAST, 64'd1,
                 '0, '0), 1, 0, blft_pkg::RSN_NONE},
            // none as new active and a foreign cookie leave the active port alone
            '{mk(blft_pkg::OP_ACTIVE, 48'h0, 16'h0, 16'd0, blft_pkg::CLS_UCAST, 64'd0,
                 16'd0, 64'd0), 1, 0, blft_pkg::RSN_NONE},
            '{mk(blft_pkg::OP_ACTIVE, 48'h0, 16'h0, 16'd0, blft_pkg::CLS_UCAST, 64'd0,
                 16'd4, '1), 1, 0, blft_pkg::RSN_NONE},
            '{mk(blft_pkg::OP_INGRESS, 48'h5, 16'h5, 16'd4, blft_pkg::CLS_IGMP, 64'd1,
                 '0, '0), 1, 1, blft_pkg::RSN_MCAST},
            // parse error on egress learns nothing
            '{mk(blft_pkg::OP_EGRESS, 48'h0, 16'h0, 16'd5, blft_pkg::CLS_PARSE, 64'd50,
                 '0, '0), 1, 0, blft_pkg::RSN_NONE},
            '{mk(blft_pkg::OP_INGRESS, 48'h0, 16'h0, 16'd6, blft_pkg::CLS_UCAST, 64'd51,
                 '0, '0), 1, 0, blft_pkg::RSN_NONE},
            // expiry sum wraps past 2^64
            '{mk(blft_pkg::OP_EGRESS, 48'h3, 16'h3, 16'd3, blft_pkg::CLS_UCAST, '1,
                 '0, '0), 0, 0, blft_pkg::RSN_NONE},
            '{mk(blft_pkg::OP_INGRESS, 48'h3, 16'h3, 16'd4, blft_pkg::CLS_UCAST, 64'd5,
                 '0, '0), 0, 0, blft_pkg::RSN_NONE},
            '{mk(blft_pkg::OP_EGRESS, 48'h4, 16'h4, '1, blft_pkg::CLS_GARP, '1,
                 '0, '0), 0, 0, blft_pkg::RSN_NONE},
            '{mk(blft_pkg::OP_INGRESS, 48'h4, 16'h4, 16'd1, blft_pkg::CLS_GARP, 64'd7,
                 '0, '0), 0, 0, blft_pkg::RSN_NONE}
        };
        foreach (dir_rows[i]) begin
            row = dir_rows[i];
            send(row.it, row.typed, {row.reason, row.drop});
        end
        drain();

        // random phases, each under its own registers and handshake pressure
        for (int phase = 0; phase < 4; phase++) begin
            bond = (phase == 1) ? 16'hFFFF : 16'($urandom);
            cookie = (phase == 2) ? '1 : rand64();
            case (phase)
                0: begin
                    write_reg(blft_pkg::REG_STATE_LT, 64'd60_000_000_000);
                    write_reg(blft_pkg::REG_LOCK_LT, 64'd5_000_000_000);
                end
                1: begin
                    write_reg(blft_pkg::REG_STATE_LT, 64'(LT_MAX));
                    write_reg(blft_pkg::REG_LOCK_LT, 64'd0);
                end
                2: begin
                    write_reg(blft_pkg::REG_STATE_LT, 64'd0);
                    write_reg(blft_pkg::REG_LOCK_LT, 64'(LT_MAX));
                end
                default: begin
                    write_reg(blft_pkg::REG_STATE_LT,
                              64'($urandom_range(1, 100)) * 64'd1_000_000_000);
                    write_reg(blft_pkg::REG_LOCK_LT,
                              64'($urandom_range(1, 50)) * 64'd1_000_000_000);
                end
            endcase
            write_reg(blft_pkg::REG_BOND_IF, 64'(bond));
            write_reg(blft_pkg::REG_NS_COOKIE, cookie);
            // last phase runs close to the top of the time range so sums wrap
            t_base = (phase == 3) ? 64'hFFFF_FFF0_0000_0000 : rand64() >> 2;
            case (phase)
                0: begin gap_pct = 0;  stall_pct = 0;  end
                1: begin gap_pct = 53; stall_pct = 0;  end
                2: begin gap_pct = 0;  stall_pct = 53; end
                default: begin gap_pct = 38; stall_pct = 38; end
            endcase
            for (int n = 0; n < 100; n++)
                // phase two opens with a burst of new keys to force evictions
                send(random_item(phase == 2 && n < 70), 0, '0);
            drain();
        end

        repeat (150) @(negedge i_clk);
        $display("covered %0d transfers in, %0d verdicts out, %0d drops, %0d lru evictions",
                 items_sent, verdicts_seen, drops_seen, evict_fills);
        if (errors == 0 && verdicts_due.size() == 0) begin
            $display("bond_loop_filter_table_test: done, clean");
        end else begin
            $display("%0d mismatches, %0d verdicts never seen", errors, verdicts_due.size());
            $display("bond_loop_filter_table_test: done, errors");
        end
        $finish;
    end

endmodule
